@@ design/cstrip_pkg.sv @@
// Package for the C comment stripper: character codes, state and result types,
// and the per-byte step function. No dependencies.
`timescale 1ns / 1ps

package cstrip_pkg;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// Output queue geometry.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;
	localparam int OUTQ_CW    = 3;

	typedef struct packed {
		logic in_block;
		logic in_string_lit;
		logic in_char_lit;
		logic escape_next;
		logic skip_rest_of_line;
		logic held_slash;
		logic held_star;
	} cs_state_t;

	typedef struct packed {
		logic       line_done;
		logic       has_byte;
		logic [7:0] out_byte;
	} result_t;

	// Results pushed into the output queue for one item.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    e0;
		result_t    e1;
	} push_t;

	typedef struct packed {
		cs_state_t nxt;
		push_t     push;
	} step_t;

	// Literal tracking for a kept byte.
	function automatic cs_state_t cs_track(cs_state_t st, logic [7:0] c);
		cs_state_t ns;
		ns = st;
		if (st.escape_next) begin
			ns.escape_next = 1'b0;
		end else if (st.in_string_lit) begin
			if (c == CH_BSLASH) ns.escape_next = 1'b1;
			else if (c == CH_DQUOTE) ns.in_string_lit = 1'b0;
		end else if (st.in_char_lit) begin
			if (c == CH_BSLASH) ns.escape_next = 1'b1;
			else if (c == CH_SQUOTE) ns.in_char_lit = 1'b0;
		end else if (c == CH_DQUOTE) begin
			ns.in_string_lit = 1'b1;
		end else if (c == CH_SQUOTE) begin
			ns.in_char_lit = 1'b1;
		end
		return ns;
	endfunction

	// One source byte: next state and zero to two results.
	function automatic step_t cs_step(cs_state_t st, logic [7:0] c, logic eol);
		cs_state_t  ns;
		logic [1:0] n;
		logic [7:0] k0;
		logic [7:0] k1;
		step_t      res;
		ns = st;
		n  = 2'd0;
		k0 = 8'd0;
		k1 = 8'd0;
		if (st.skip_rest_of_line) begin
			ns = st;
		end else if (st.in_block) begin
			if (st.held_star && c == CH_SLASH) begin
				ns.in_block  = 1'b0;
				ns.held_star = 1'b0;
			end else begin
				ns.held_star = (c == CH_STAR);
			end
		end else if (st.held_slash) begin
			ns.held_slash = 1'b0;
			if (c == CH_STAR) begin
				ns.in_block  = 1'b1;
				ns.held_star = 1'b0;
			end else if (c == CH_SLASH) begin
				ns.skip_rest_of_line = 1'b1;
			end else begin
				n  = 2'd2;
				k0 = CH_SLASH;
				k1 = c;
				ns = cs_track(ns, c);
			end
		end else if (!st.in_string_lit && !st.in_char_lit && c == CH_SLASH) begin
			if (eol) begin
				n  = 2'd1;
				k0 = CH_SLASH;
			end else begin
				ns.held_slash = 1'b1;
			end
		end else begin
			n  = 2'd1;
			k0 = c;
			ns = cs_track(ns, c);
		end

		res.push.e0.has_byte  = 1'b1;
		res.push.e0.out_byte  = k0;
		res.push.e0.line_done = eol && (n == 2'd1);
		res.push.e1.has_byte  = 1'b1;
		res.push.e1.out_byte  = k1;
		res.push.e1.line_done = eol;
		if (eol) begin
			ns.in_string_lit     = 1'b0;
			ns.in_char_lit       = 1'b0;
			ns.escape_next       = 1'b0;
			ns.skip_rest_of_line = 1'b0;
			ns.held_slash        = 1'b0;
			ns.held_star         = 1'b0;
			if (n == 2'd0) begin
				n = 2'd1;
				res.push.e0.has_byte  = 1'b0;
				res.push.e0.out_byte  = 8'd0;
				res.push.e0.line_done = 1'b1;
			end
		end
		res.push.cnt = n;
		res.nxt      = ns;
		return res;
	endfunction

endpackage

@@ design/c_comment_stripper_top.sv @@
// C comment stripper, top level: input register, per-byte step logic with the
// scanner state register, and the output queue. Depends on cstrip_pkg, cstrip_outq.
// Path: the first result of an item passes the input register and the output queue
//   before it shows on the output port; a queue without room can hold the item between.
// Throughput: 1 input item per cycle while the queue has room; an item that yields two
//   results (a held slash released together with the next byte) sends them out in turn.
// Limit: the output side drains one result a cycle, when ready, from a 4-entry queue.
// Reset: arst_n clears the scanner state, the input valid flag and the queue pointers and count.
`timescale 1ns / 1ps

module c_comment_stripper_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // end_of_line
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] has_byte
	output logic       m_axis_tlast    // line_done
);
	import cstrip_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;

	// Scanner state: comment, literal and lookahead flags
	cs_state_t  state_q;
	step_t      step;
	logic       room;
	logic       advance;
	logic       in_take;
	result_t    head;

	// Process the held item as soon as the queue can take two results.
	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign step          = cs_step(state_q, byte_s1, eol_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage: load on every accept.
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= s_axis_tdata;
			eol_s1  <= s_axis_tlast;
		end
	end

	// Advance the scanner once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= step.nxt;
		end
	end

	cstrip_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (step.push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_res   (head),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = head.out_byte;
	assign m_axis_tuser = head.has_byte;
	assign m_axis_tlast = head.line_done;

endmodule

@@ design/cstrip_outq.sv @@
// Output queue of the C comment stripper: takes up to two results a cycle,
// hands out one a cycle while out_ready is high on a stream port. Depends on cstrip_pkg.
`timescale 1ns / 1ps

module cstrip_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  cstrip_pkg::push_t  push,
	output logic               room,
	output logic               out_valid,
	output cstrip_pkg::result_t out_res,
	input  logic               out_ready
);
	import cstrip_pkg::*;

	result_t              mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_q;
	logic [OUTQ_AW-1:0]   rd_q;
	logic [OUTQ_CW-1:0]   cnt_q;
	logic                 pop;
	logic [OUTQ_CW-1:0]   add;

	// Room for the worst case of two results.
	assign room      = (cnt_q <= OUTQ_CW'(OUTQ_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign add       = push_en ? OUTQ_CW'(push.cnt) : '0;

	always_ff @(posedge clk) begin
		if (push_en && push.cnt != 2'd0) mem_q[wr_q] <= push.e0;
		if (push_en && push.cnt == 2'd2) mem_q[wr_q + OUTQ_AW'(1)] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OUTQ_AW'(add);
			if (pop) rd_q <= rd_q + OUTQ_AW'(1);
			cnt_q <= cnt_q + add - OUTQ_CW'(pop);
		end
	end

endmodule

@@ design/cstrip_chk.sv @@
// Port-level checker for the C comment stripper and its bind to the top level.
// Depends on c_comment_stripper_top port names only.
`timescale 1ns / 1ps

module cstrip_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	// An empty result only marks a line end and carries a zero byte.
	a_empty_is_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
		else $error("empty result without line end or with nonzero byte");

	// Input stalls only when the output side is backed up.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled while no result is pending");

	// A waiting input item stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("waiting input item changed");

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn before taken");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind c_comment_stripper_top cstrip_chk u_cstrip_chk (.*);
